// File: hdl/aes128_ctr_stream_cipher_core_macros.svh
// Assertion macros for the counter-mode cipher core.
`ifndef AES128_CTR_STREAM_CIPHER_CORE_MACROS_SVH
`define AES128_CTR_STREAM_CIPHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ACC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ACC_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define ACC_ASSERT(label, clk, rst_n, prop, msg)
`define ACC_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// File: hdl/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// aesctr_pkg
// Types, constants and AES helper functions shared by the cipher core.
// ----------------------------------------------------------------------------
package aesctr_pkg;

    localparam int BlockBytes = 16;
    localparam int HalfBytes  = 8;
    localparam int Rounds     = 10;

    localparam logic [1:0] REG_KEY_LOW   = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH  = 2'd1;
    localparam logic [1:0] REG_NONCE     = 2'd2;

    typedef struct packed {
        logic [63:0] data_low;
        logic [63:0] data_high;
        logic [4:0]  byte_count;
        logic        message_end;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic [4:0]  valid_bytes;
        logic        final_block;
    } out_item_t;

    // Side data that rides along the round chain with each block.
    typedef struct packed {
        logic [127:0] msg;
        logic [4:0]   byte_count;
        logic         message_end;
    } side_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
            4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
            4'd9: v = 8'h1b; 4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a block sits at bits 8*i+7 : 8*i.
    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [3:0] r);
        logic [127:0] n;
        logic [31:0]  t;
        t = {aesctr_pkg::sbox(k[103:96]), aesctr_pkg::sbox(k[127:120]),
             aesctr_pkg::sbox(k[119:112]),
             aesctr_pkg::sbox(k[111:104]) ^ aesctr_pkg::rcon(r)};
        n[31:0]   = k[31:0] ^ t;
        n[63:32]  = k[63:32] ^ n[31:0];
        n[95:64]  = k[95:64] ^ n[63:32];
        n[127:96] = k[127:96] ^ n[95:64];
        return n;
    endfunction

    function automatic logic [127:0] cipher_round(input logic [127:0] s,
                                                  input logic [127:0] rk,
                                                  input logic last);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0]   a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[8*(i+4*c) +: 8] = aesctr_pkg::sbox(s[8*(i+4*((c+i)%4)) +: 8]);
            end
        end
        m = t;
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0  = t[32*c +: 8];
                a1  = t[32*c+8 +: 8];
                a2  = t[32*c+16 +: 8];
                a3  = t[32*c+24 +: 8];
                all = a0 ^ a1 ^ a2 ^ a3;
                m[32*c +: 8]    = a0 ^ all ^ aesctr_pkg::xtime(a0 ^ a1);
                m[32*c+8 +: 8]  = a1 ^ all ^ aesctr_pkg::xtime(a1 ^ a2);
                m[32*c+16 +: 8] = a2 ^ all ^ aesctr_pkg::xtime(a2 ^ a3);
                m[32*c+24 +: 8] = a3 ^ all ^ aesctr_pkg::xtime(a3 ^ a0);
            end
        end
        return m ^ rk;
    endfunction

endpackage

// File: hdl/aesctr_round_cell.sv
// ----------------------------------------------------------------------------
// aesctr_round_cell
// One AES round with its on-the-fly key step; hands state and key onward.
// ----------------------------------------------------------------------------
module aesctr_round_cell #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               valid_in,
    input  logic [127:0]       state_in,
    input  logic [127:0]       key_in,
    input  aesctr_pkg::side_t  side_in,
    output logic               valid_out,
    output logic [127:0]       state_out,
    output logic [127:0]       key_out,
    output aesctr_pkg::side_t  side_out
);

    logic               valid_reg;
    logic [127:0]       state_reg;
    logic [127:0]       key_reg;
    aesctr_pkg::side_t  side_reg;
    logic [127:0]       key_next;
    logic [127:0]       state_next;

    assign key_next   = aesctr_pkg::next_round_key(key_in, ROUND);
    assign state_next = aesctr_pkg::cipher_round(state_in, key_next,
                                                 ROUND == 4'(aesctr_pkg::Rounds));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            side_reg  <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
    assign side_out  = side_reg;

endmodule

// File: hdl/aes128_ctr_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// aes128_ctr_stream_cipher_core
// AES-128 counter-mode cipher: ten round cells, one block a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes key_low (0), key_high (1) and nonce_value (2); write
//   only while no item is in flight. Other indexes are ignored.
//   in channel takes one block of up to 16 bytes per item; out channel gives
//   the block XORed with the keystream, bytes past byte_count zero.
//   Path: the input stage loads at the accepting edge, then ten round cells
//   and one output register. Throughput: one item per cycle while the
//   output is not stalled, set by the chain of round cells, each of which
//   takes a new block whenever the chain advances.
//   The chain moves as a whole; when the receiver stalls with a result
//   waiting, the chain holds and in_ready drops in the same cycle.
//   Reset clears the registers to zero, the block counter to zero and all
//   stage valids. The counter returns to zero after a message_end item.
// ----------------------------------------------------------------------------
`include "aes128_ctr_stream_cipher_core_macros.svh"

module aes128_ctr_stream_cipher_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  aesctr_pkg::in_item_t   in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output aesctr_pkg::out_item_t  out_item
);

    localparam int Cells = aesctr_pkg::Rounds;

    logic [63:0] key_low_reg, key_high_reg, nonce_reg, counter_reg;
    logic        s0_valid_reg;
    logic [127:0] s0_state_reg, s0_key_reg;
    aesctr_pkg::side_t s0_side_reg;

    logic               v   [0:Cells];
    logic [127:0]       st  [0:Cells];
    logic [127:0]       ky  [0:Cells];
    aesctr_pkg::side_t  sd  [0:Cells];

    logic        out_valid_reg;
    aesctr_pkg::out_item_t out_reg;
    logic        advance;
    logic        in_fire;
    logic [127:0] mask;
    logic [4:0]  count_sat;

    assign cfg_ready = 1'b1;
    // The whole chain moves unless the output register is full and stalled.
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= 64'd0;
            key_high_reg <= 64'd0;
            nonce_reg    <= 64'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                aesctr_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                aesctr_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aesctr_pkg::REG_NONCE:    nonce_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg  <= 64'd0;
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                counter_reg <= in_item.message_end ? 64'd0 : counter_reg + 64'd1;
            end
            if (advance)
            begin
                s0_valid_reg <= in_fire;
            end
        end
    end

    // Initial AddRoundKey happens at entry.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_state_reg <= {counter_reg, nonce_reg} ^ {key_high_reg, key_low_reg};
            s0_key_reg   <= {key_high_reg, key_low_reg};
            s0_side_reg  <= '{msg: {in_item.data_high, in_item.data_low},
                               byte_count: in_item.byte_count,
                               message_end: in_item.message_end};
        end
    end

    assign v[0]  = s0_valid_reg;
    assign st[0] = s0_state_reg;
    assign ky[0] = s0_key_reg;
    assign sd[0] = s0_side_reg;

    for (genvar g = 0; g < Cells; g++)
    begin : g_cell
        aesctr_round_cell #(.ROUND(4'(g + 1))) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (v[g]),
            .state_in  (st[g]),
            .key_in    (ky[g]),
            .side_in   (sd[g]),
            .valid_out (v[g+1]),
            .state_out (st[g+1]),
            .key_out   (ky[g+1]),
            .side_out  (sd[g+1])
        );
    end

    assign count_sat = (sd[Cells].byte_count > 5'd16) ? 5'd16 : sd[Cells].byte_count;

    always_comb
    begin
        for (int i = 0; i < aesctr_pkg::BlockBytes; i++)
        begin
            mask[8*i +: 8] = (5'(i) < count_sat) ? 8'hff : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= v[Cells];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            {out_reg.result_high, out_reg.result_low} <=
                (sd[Cells].msg ^ st[Cells]) & mask;
            out_reg.valid_bytes <= sd[Cells].byte_count;
            out_reg.final_block <= sd[Cells].message_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    `ACC_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")
    `ACC_ASSERT_NEXT(a_ctr_clear, clk, rst_n, in_fire && in_item.message_end, counter_reg == 64'd0, "counter not cleared")
    `ACC_ASSERT(a_no_accept_stall, clk, rst_n, (out_valid && !out_ready) |-> !in_ready, "accept while stalled")
    `ACC_ASSERT_NEXT(a_entry, clk, rst_n, in_fire, s0_valid_reg, "accepted item lost at entry")

endmodule
